// ===== design/rprc_pkg.sv =====
// Shared types, constants and elaboration-time functions of the readout phase ramp corrector.
`timescale 1ns / 1ps
`default_nettype none
package rprc_pkg;

	localparam int SAMPLE_W          = 16;
	localparam int PHASE_W           = 16;
	localparam int MAX_READOUT       = 1024;
	localparam int POS_W             = $clog2(MAX_READOUT);
	localparam int REG_W             = POS_W + 1;
	localparam int GUARD_W           = 6;
	localparam int GAIN_FRAC         = 20;
	localparam int GAIN_ONE_W        = 30;
	localparam int TURN_W            = 32;
	localparam int Z_W               = TURN_W;
	localparam int DP_W              = SAMPLE_W + GUARD_W + 3;
	localparam int GAIN_W            = GAIN_FRAC + 2;
	localparam int MAX_STAGES        = 32;
	localparam int CORDIC_STAGES_DEF = 16;

	// Configuration register indexes.
	localparam int CFG_ADDR_W = 1;
	localparam logic [CFG_ADDR_W-1:0] REG_READOUT_LENGTH  = 1'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_CORRECTED_LINES = 1'd1;

	localparam logic [REG_W-1:0] READOUT_LENGTH_RST  = REG_W'(256);
	localparam logic [REG_W-1:0] CORRECTED_LINES_RST = REG_W'(256);

	// arctan(2^-i) in units of 2^32 per full turn.
	localparam logic [Z_W-1:0] ATAN_TURNS [MAX_STAGES] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81,
		32'd41,        32'd20,        32'd10,        32'd5,
		32'd3,         32'd1,         32'd1,         32'd0
	};

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample_real;
		logic signed [SAMPLE_W-1:0] sample_imag;
		logic        [POS_W-1:0]    readout_position;
		logic        [POS_W-1:0]    line_index;
		logic signed [PHASE_W-1:0]  phase_slope;
		logic        [PHASE_W-1:0]  phase_offset;
	} in_item_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] rotated_real;
		logic signed [SAMPLE_W-1:0] rotated_imag;
	} out_item_t;

	// Data handed from cell to cell along the rotation chain.
	typedef struct packed {
		logic                   byp;
		logic signed [DP_W-1:0] x;
		logic signed [DP_W-1:0] y;
		logic signed [Z_W-1:0]  z;
	} lane_t;

	// Squared CORDIC gain scaled by 2^60, evaluated at elaboration.
	function automatic logic [63:0] rprc_gain_sq(input int stages);
		logic [63:0] g;
		g = 64'd1 << GAIN_ONE_W;
		for (int i = 0; i < MAX_STAGES; i++) begin
			if (i < stages) begin
				g = g + (g >> (2 * i));
			end
		end
		return g << GAIN_ONE_W;
	endfunction

	// Integer square root by the digit-pair method, evaluated at elaboration.
	function automatic logic [63:0] rprc_isqrt(input logic [63:0] v);
		logic [63:0] rem;
		logic [63:0] root;
		logic [63:0] bitv;
		rem  = v;
		root = 64'd0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= root + bitv) begin
				rem  = rem - (root + bitv);
				root = (root >> 1) + bitv;
			end else begin
				root = root >> 1;
			end
			bitv = bitv >> 2;
		end
		return root;
	endfunction

endpackage
`default_nettype wire

// ===== design/readout_phase_ramp_corrector_core.sv =====
// Top level of the readout phase ramp corrector: registers, front stage, cell chain, gain stage.
//
//  Channel  | Direction | Handshake            | Carries
//  ---------+-----------+----------------------+------------------------------------------
//  in       | into      | in_valid / in_ready  | in_data: sample, position, line, slope, offset
//  out      | out of    | out_valid / out_ready| out_data: rotated sample
//  cfg      | into      | cfg_we               | cfg_addr, cfg_wdata: register write
//
// One request is accepted every clock cycle while the output side keeps taking results.
// A request passes through the front stage, then the rotation cells in order, each with its
// own register, and then the gain multiply and rounding stages.
// Every stage has its own valid bit, so bubbles collapse and new requests are still taken
// while a finished result waits at the output.
// Reset clears the valid bits and loads 256 into both configuration registers; there is
// no clearing pass, so the input is ready as soon as reset is released.
`timescale 1ns / 1ps
`default_nettype none
module readout_phase_ramp_corrector_core
	import rprc_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_item_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_item_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [REG_W-1:0]      cfg_wdata
);

	logic [REG_W-1:0] readout_length_q;
	logic [REG_W-1:0] corrected_lines_q;

	// Link k joins the producer of lane[k] to its consumer; link 0 leaves the front stage
	// and link CORDIC_STAGES enters the gain stage.
	lane_t                  lane [0:CORDIC_STAGES];
	logic [CORDIC_STAGES:0] vld;
	logic [CORDIC_STAGES:0] rdy;

	// Configuration registers. A write takes effect at once, so writes are meant to come
	// only while the pipeline is empty.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			readout_length_q  <= READOUT_LENGTH_RST;
			corrected_lines_q <= CORRECTED_LINES_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_READOUT_LENGTH: begin
					readout_length_q <= cfg_wdata;
				end
				REG_CORRECTED_LINES: begin
					corrected_lines_q <= cfg_wdata;
				end
				default: begin
				end
			endcase
		end
	end

	// The front stage computes the ramp phase and pre-rotates by the quarter turn.
	rprc_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.readout_length  (readout_length_q),
		.corrected_lines (corrected_lines_q),
		.up_valid        (in_valid),
		.up_ready        (in_ready),
		.up_data         (in_data),
		.dn_valid        (vld[0]),
		.dn_ready        (rdy[0]),
		.dn_lane         (lane[0])
	);

	// The chain of rotation cells; cell k shifts by k and uses the k-th arctangent.
	for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cell
		rprc_cell #(
			.IDX (k)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (vld[k]),
			.up_ready (rdy[k]),
			.up_lane  (lane[k]),
			.dn_valid (vld[k+1]),
			.dn_ready (rdy[k+1]),
			.dn_lane  (lane[k+1])
		);
	end

	// Gain compensation, rounding and saturation; its last register drives the output.
	rprc_gain #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_gain (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (vld[CORDIC_STAGES]),
		.up_ready (rdy[CORDIC_STAGES]),
		.up_lane  (lane[CORDIC_STAGES]),
		.dn_valid (out_valid),
		.dn_ready (out_ready),
		.dn_data  (out_data)
	);

	// A stalled link keeps its request and its data until the consumer takes it.
	for (genvar k = 0; k <= CORDIC_STAGES; k++) begin : g_chk
		a_link_hold: assert property (@(posedge clk) disable iff (!arst_n)
			vld[k] && !rdy[k] |=> vld[k] && $stable(lane[k]))
			else $error("pipeline link dropped or changed a stalled request");
	end

	// With every link empty the front stage must be able to take a request.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		vld == '0 |-> in_ready)
		else $error("input not ready although the cell chain is empty");

	// A write to the readout length register is visible in the following cycle.
	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_addr == REG_READOUT_LENGTH |=> readout_length_q == $past(cfg_wdata))
		else $error("readout length register did not take the written value");

endmodule
`default_nettype wire

// ===== design/rprc_front.sv =====
// Front stage: phase ramp, bypass decision and quarter-turn pre-rotation.
`timescale 1ns / 1ps
`default_nettype none
module rprc_front
	import rprc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [REG_W-1:0] readout_length,
	input  wire logic [REG_W-1:0] corrected_lines,
	input  wire logic             up_valid,
	output logic                  up_ready,
	input  wire in_item_t         up_data,
	output logic                  dn_valid,
	input  wire logic             dn_ready,
	output lane_t                 dn_lane
);

	localparam logic [1:0] QUAD_0 = 2'd0;
	localparam logic [1:0] QUAD_1 = 2'd1;
	localparam logic [1:0] QUAD_2 = 2'd2;
	localparam logic [1:0] QUAD_3 = 2'd3;

	logic        [POS_W-1:0]         half;
	logic signed [POS_W:0]           diff;
	logic signed [POS_W+PHASE_W:0]   prod;
	logic        [PHASE_W-1:0]       phase;
	logic        [1:0]               quad;
	logic signed [DP_W-1:0]          xs;
	logic signed [DP_W-1:0]          ys;
	lane_t                           nxt;
	logic                            vld_q;
	lane_t                           lane_q;

	always_comb begin
		half  = readout_length[REG_W-1:1];
		diff  = $signed({1'b0, up_data.readout_position}) - $signed({1'b0, half});
		prod  = diff * up_data.phase_slope;
		phase = prod[PHASE_W-1:0] + up_data.phase_offset;
		quad  = phase[PHASE_W-1 -: 2];
		xs = {{(DP_W-SAMPLE_W-GUARD_W){up_data.sample_real[SAMPLE_W-1]}},
			up_data.sample_real, {GUARD_W{1'b0}}};
		ys = {{(DP_W-SAMPLE_W-GUARD_W){up_data.sample_imag[SAMPLE_W-1]}},
			up_data.sample_imag, {GUARD_W{1'b0}}};

		nxt.byp = ({1'b0, up_data.line_index} >= corrected_lines);
		nxt.z   = {2'b00, phase[PHASE_W-3:0], {(TURN_W-PHASE_W){1'b0}}};
		case (quad)
			QUAD_0: begin
				nxt.x = xs;
				nxt.y = ys;
			end
			QUAD_1: begin
				nxt.x = -ys;
				nxt.y = xs;
			end
			QUAD_2: begin
				nxt.x = -xs;
				nxt.y = -ys;
			end
			QUAD_3: begin
				nxt.x = ys;
				nxt.y = -xs;
			end
			default: begin
				nxt.x = xs;
				nxt.y = ys;
			end
		endcase

		// A bypassed sample keeps its scaled value and no residual angle.
		if (nxt.byp) begin
			nxt.x = xs;
			nxt.y = ys;
			nxt.z = '0;
		end
	end

	assign up_ready = !vld_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			lane_q <= nxt;
		end
	end

	assign dn_valid = vld_q;
	assign dn_lane  = lane_q;

endmodule
`default_nettype wire

// ===== design/rprc_cell.sv =====
// One CORDIC rotation cell with its own valid/ready register stage.
`timescale 1ns / 1ps
`default_nettype none
module rprc_cell
	import rprc_pkg::*;
#(
	parameter int IDX = 0
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  up_valid,
	output logic       up_ready,
	input  wire lane_t up_lane,
	output logic       dn_valid,
	input  wire logic  dn_ready,
	output lane_t      dn_lane
);

	localparam logic [$clog2(MAX_STAGES)-1:0] ATAN_IDX = $clog2(MAX_STAGES)'(IDX);
	localparam logic [Z_W-1:0] ATAN = ATAN_TURNS[ATAN_IDX];

	logic signed [DP_W-1:0] dx;
	logic signed [DP_W-1:0] dy;
	lane_t                  nxt;
	logic                   vld_q;
	lane_t                  lane_q;

	always_comb begin
		dx  = up_lane.y >>> IDX;
		dy  = up_lane.x >>> IDX;
		nxt = up_lane;
		if (!up_lane.byp) begin
			// Rotate toward a zero residual angle.
			if (!up_lane.z[Z_W-1]) begin
				nxt.x = up_lane.x - dx;
				nxt.y = up_lane.y + dy;
				nxt.z = up_lane.z - ATAN;
			end else begin
				nxt.x = up_lane.x + dx;
				nxt.y = up_lane.y - dy;
				nxt.z = up_lane.z + ATAN;
			end
		end
	end

	assign up_ready = !vld_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (up_ready) begin
			vld_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			lane_q <= nxt;
		end
	end

	assign dn_valid = vld_q;
	assign dn_lane  = lane_q;

endmodule
`default_nettype wire

// ===== design/rprc_gain.sv =====
// Gain compensation, rounding and saturation, ending in the output register.
`timescale 1ns / 1ps
`default_nettype none
module rprc_gain
	import rprc_pkg::*;
#(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  up_valid,
	output logic       up_ready,
	input  wire lane_t up_lane,
	output logic       dn_valid,
	input  wire logic  dn_ready,
	output out_item_t  dn_data
);

	localparam int P_W = DP_W + GAIN_W;
	localparam int RSH = GAIN_FRAC + GUARD_W;
	localparam logic [63:0] GAIN_ROOT = rprc_isqrt(rprc_gain_sq(CORDIC_STAGES));
	localparam logic [63:0] GAIN_RAW =
		((64'd1 << (GAIN_ONE_W + GAIN_FRAC)) + (GAIN_ROOT >> 1)) / GAIN_ROOT;
	localparam logic signed [GAIN_W-1:0] GAIN_K = GAIN_W'(GAIN_RAW);
	localparam logic signed [GAIN_W-1:0] UNITY  = GAIN_W'(1) << GAIN_FRAC;
	localparam logic signed [P_W-1:0] HALF_LSB  = P_W'(1) << (RSH - 1);
	localparam logic signed [P_W-1:0] SAT_HI    = P_W'((1 << (SAMPLE_W - 1)) - 1);
	localparam logic signed [P_W-1:0] SAT_LO    = -SAT_HI - P_W'(1);

	function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [P_W-1:0] p);
		logic signed [P_W-1:0] r;
		r = (p + HALF_LSB) >>> RSH;
		if (r > SAT_HI) begin
			return SAT_HI[SAMPLE_W-1:0];
		end else if (r < SAT_LO) begin
			return SAT_LO[SAMPLE_W-1:0];
		end
		return r[SAMPLE_W-1:0];
	endfunction

	logic signed [GAIN_W-1:0] k_sel;
	logic signed [P_W-1:0]    mul_x;
	logic signed [P_W-1:0]    mul_y;
	logic signed [P_W-1:0]    prod_x_s1;
	logic signed [P_W-1:0]    prod_y_s1;
	logic                     vld_s1;
	logic                     vld_s2;
	out_item_t                data_s2;
	logic                     rdy_s1;
	logic                     rdy_s2;

	// A bypassed sample is scaled by exactly one so that rounding returns it unchanged.
	assign k_sel = up_lane.byp ? UNITY : GAIN_K;
	assign mul_x = up_lane.x * k_sel;
	assign mul_y = up_lane.y * k_sel;

	assign rdy_s2   = !vld_s2 || dn_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign up_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= up_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && up_valid) begin
			prod_x_s1 <= mul_x;
			prod_y_s1 <= mul_y;
		end
		if (rdy_s2 && vld_s1) begin
			data_s2.rotated_real <= round_sat(prod_x_s1);
			data_s2.rotated_imag <= round_sat(prod_y_s1);
		end
	end

	assign dn_valid = vld_s2;
	assign dn_data  = data_s2;

endmodule
`default_nettype wire
